[design/life_like_automaton_generation_core_assert.svh]
// Assertion macros for the generation core RTL.
// Included by llag_rule, which checks its own pipeline behaviour.
`ifndef LIFE_LIKE_AUTOMATON_GENERATION_CORE_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_GENERATION_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LLAG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled in reset
`define LLAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/llag_pkg.sv]
// Types, constants and helpers for the Life-like generation core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package llag_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int MASK_W      = 9;
    localparam int WIN_W       = 9;
    localparam int ROWS_FIELD_W = 11;
    localparam int COLS_FIELD_W = 7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BIRTH_MASK   = 2'd0,
        REG_SURVIVE_MASK = 2'd1,
        REG_GRID_ROWS    = 2'd2,
        REG_GRID_COLS    = 2'd3
    } cfg_reg_t;

    localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;
    localparam int ROWS_RESET = 32;
    localparam int COLS_RESET = 64;

    // window bit = column * 3 + row, column 0 left, row 0 top
    localparam logic [WIN_W-1:0] WIN_TOP    = 9'h049;
    localparam logic [WIN_W-1:0] WIN_BOTTOM = 9'h124;
    localparam logic [WIN_W-1:0] WIN_LEFT   = 9'h007;
    localparam logic [WIN_W-1:0] WIN_RIGHT  = 9'h1C0;

    typedef struct packed {
        logic kind;
        logic alive;
    } cell_t;

    typedef struct packed {
        logic next_alive;
        logic last_of_frame;
    } result_t;

    typedef struct packed {
        logic [MASK_W-1:0] birth_mask;
        logic [MASK_W-1:0] survive_mask;
    } rule_cfg_t;

    typedef struct packed {
        logic valid;
        logic cur;
        logic up;
        logic mid;
        logic emit;
        logic last;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } stage_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[design/life_like_automaton_generation_core.sv]
// Top level of the Life-like generation core: streams one generation.
// Depends on llag_pkg, llag_cfg, llag_front and llag_rule.
//
//  channel  | signals                                 | direction
//  ---------+-----------------------------------------+----------
//  cell     | cell_valid, cell_ready, cell_data       | in
//  result   | result_valid, result_ready, result      | out
//  cfg      | cfg_write, cfg_index, cfg_data          | in
//
// One beat a cycle sustained while results are taken; the line store read
// is the first of the two stages and the result register the second.
// Reset loads default geometry and masks and clears counters and the window;
// stale line store contents reach only masked window positions.
// A stalled result holds only items that would produce a result behind it.
`timescale 1ns / 1ps
`default_nettype none

module life_like_automaton_generation_core
    import llag_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cell_valid,
    output logic                        cell_ready,
    input  wire cell_t                  cell_data,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_t                     result,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLS + 1);

    rule_cfg_t     rule_cfg;
    logic [RW-1:0] rows;
    logic [CW-1:0] cols;
    logic          restart;
    logic          s1_go;
    stage_t        s1;

    llag_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .RW       (RW),
        .CW       (CW)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rule_cfg  (rule_cfg),
        .rows      (rows),
        .cols      (cols),
        .restart   (restart)
    );

    llag_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .RW       (RW),
        .CW       (CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .rows       (rows),
        .cols       (cols),
        .restart    (restart),
        .s1_go      (s1_go),
        .s1         (s1)
    );

    llag_rule u_rule (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1           (s1),
        .rule_cfg     (rule_cfg),
        .s1_go        (s1_go),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

[design/llag_cfg.sv]
// Configuration registers: rule masks and saturated grid geometry.
// Depends on llag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module llag_cfg
    import llag_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 64,
    parameter int RW = $clog2(MAX_ROWS + 1),
    parameter int CW = $clog2(MAX_COLS + 1)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output rule_cfg_t                   rule_cfg,
    output logic [RW-1:0]               rows,
    output logic [CW-1:0]               cols,
    output logic                        restart
);

    localparam int ROWS_INIT = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
    localparam int COLS_INIT = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;

    rule_cfg_t       rule_reg, rule_next;
    logic [RW-1:0]   rows_reg, rows_next;
    logic [CW-1:0]   cols_reg, cols_next;
    logic [ROWS_FIELD_W-1:0] rows_val;
    logic [COLS_FIELD_W-1:0] cols_val;
    logic [RW-1:0]   rows_sat;
    logic [CW-1:0]   cols_sat;

    assign rows_val = cfg_data[ROWS_FIELD_W-1:0];
    assign cols_val = cfg_data[COLS_FIELD_W-1:0];

    always_comb
    begin
        if (rows_val == '0)
            rows_sat = RW'(1);
        else if (32'(rows_val) > 32'(MAX_ROWS))
            rows_sat = RW'(MAX_ROWS);
        else
            rows_sat = RW'(rows_val);

        if (cols_val == '0)
            cols_sat = CW'(1);
        else if (32'(cols_val) > 32'(MAX_COLS))
            cols_sat = CW'(MAX_COLS);
        else
            cols_sat = CW'(cols_val);
    end

    always_comb
    begin
        rule_next = rule_reg;
        rows_next = rows_reg;
        cols_next = cols_reg;
        restart   = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_BIRTH_MASK:   rule_next.birth_mask   = cfg_data[MASK_W-1:0];
                REG_SURVIVE_MASK: rule_next.survive_mask = cfg_data[MASK_W-1:0];
                REG_GRID_ROWS:
                begin
                    rows_next = rows_sat;
                    restart   = 1'b1;
                end
                REG_GRID_COLS:
                begin
                    cols_next = cols_sat;
                    restart   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg.birth_mask   <= BIRTH_RESET;
            rule_reg.survive_mask <= SURVIVE_RESET;
            rows_reg <= RW'(ROWS_INIT);
            cols_reg <= CW'(COLS_INIT);
        end
        else
        begin
            rule_reg <= rule_next;
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    assign rule_cfg = rule_reg;
    assign rows     = rows_reg;
    assign cols     = cols_reg;

endmodule

`default_nettype wire

[design/llag_front.sv]
// Input stage: raster position counters, line store and edge flags.
// Depends on llag_pkg; feeds the stage register to llag_rule.
`timescale 1ns / 1ps
`default_nettype none

module llag_front
    import llag_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 64,
    parameter int RW = $clog2(MAX_ROWS + 1),
    parameter int CW = $clog2(MAX_COLS + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cell_valid,
    output logic               cell_ready,
    input  wire cell_t         cell_data,
    input  wire logic [RW-1:0] rows,
    input  wire logic [CW-1:0] cols,
    input  wire logic          restart,
    input  wire logic          s1_go,
    output stage_t             s1
);

    localparam int RCW = $clog2(MAX_ROWS + 2);
    localparam int IW  = $clog2(MAX_COLS);

    logic [RCW-1:0] ir_reg, ir_next;
    logic [IW-1:0]  ic_reg, ic_next;
    logic           valid_reg, valid_next;
    logic           cell_reg, emit_reg, last_reg;
    logic           top_reg, bottom_reg, left_reg, right_reg;
    logic [IW-1:0]  addr_reg;
    logic [1:0]     rd_reg, fwd_reg;
    logic           hit_reg;
    logic [1:0]     line_mem [MAX_COLS];

    logic           accept, wr_en;
    logic [1:0]     pair, wr_data;
    logic [RCW-1:0] rows_x;
    logic [CW-1:0]  ic_inc;
    logic           wrap, at_col0;
    logic           cell_bit, emit, last, top, bottom, left, right;

    assign cell_ready = !valid_reg || s1_go;
    assign accept     = cell_valid && cell_ready;
    assign wr_en      = valid_reg && s1_go;
    assign pair       = hit_reg ? fwd_reg : rd_reg;
    assign wr_data    = {pair[0], cell_reg};

    assign rows_x  = RCW'(rows);
    assign ic_inc  = CW'(ic_reg) + CW'(1);
    assign wrap    = ic_inc >= cols;
    assign at_col0 = ic_reg == '0;

    always_comb
    begin
        cell_bit = !cell_data.kind && (ir_reg < rows_x) && cell_data.alive;
        emit     = (ir_reg >= RCW'(2)) || ((ir_reg == RCW'(1)) && !at_col0);
        last     = at_col0 && (ir_reg == rows_x + RCW'(1));
        if (at_col0)
        begin
            top    = ir_reg == RCW'(2);
            bottom = ir_reg > rows_x;
            left   = cols == CW'(1);
            right  = 1'b1;
        end
        else
        begin
            top    = ir_reg == RCW'(1);
            bottom = ir_reg >= rows_x;
            left   = ic_reg == IW'(1);
            right  = CW'(ic_reg) >= cols;
        end
    end

    always_comb
    begin
        ir_next    = ir_reg;
        ic_next    = ic_reg;
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (s1_go)
            valid_next = 1'b0;

        if (restart)
        begin
            ir_next = '0;
            ic_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                ir_next = '0;
                ic_next = '0;
            end
            else if (wrap)
            begin
                ir_next = ir_reg + RCW'(1);
                ic_next = '0;
            end
            else
            begin
                ic_next = ic_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_reg    <= '0;
            ic_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ir_reg    <= ir_next;
            ic_reg    <= ic_next;
            valid_reg <= valid_next;
        end
    end

    // line store: upper row in bit 1, middle row in bit 0
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[addr_reg] <= wr_data;
        if (accept)
        begin
            rd_reg     <= line_mem[ic_reg];
            hit_reg    <= wr_en && (addr_reg == ic_reg);
            fwd_reg    <= wr_data;
            addr_reg   <= ic_reg;
            cell_reg   <= cell_bit;
            emit_reg   <= emit;
            last_reg   <= last;
            top_reg    <= top;
            bottom_reg <= bottom;
            left_reg   <= left;
            right_reg  <= right;
        end
    end

    always_comb
    begin
        s1.valid  = valid_reg;
        s1.cur    = cell_reg;
        s1.up     = pair[1];
        s1.mid    = pair[0];
        s1.emit   = emit_reg;
        s1.last   = last_reg;
        s1.top    = top_reg;
        s1.bottom = bottom_reg;
        s1.left   = left_reg;
        s1.right  = right_reg;
    end

endmodule

`default_nettype wire

[design/llag_rule.sv]
// Window shift, neighbour count, B/S rule lookup and result register.
// Depends on llag_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "life_like_automaton_generation_core_assert.svh"

module llag_rule
    import llag_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire stage_t    s1,
    input  wire rule_cfg_t rule_cfg,
    output logic           s1_go,
    output logic           result_valid,
    input  wire logic      result_ready,
    output result_t        result
);

    logic [WIN_W-1:0] win_reg, win_next, win_live, kill;
    logic [3:0]       n;
    logic             load;
    logic             result_valid_reg;
    result_t          result_reg, result_next;

    assign s1_go = s1.valid && (!s1.emit || !result_valid_reg || result_ready);
    assign load  = s1_go && s1.emit;

    always_comb
    begin
        win_next = {s1.cur, s1.mid, s1.up, win_reg[WIN_W-1:3]};
        kill     = (s1.top    ? WIN_TOP    : '0)
                 | (s1.bottom ? WIN_BOTTOM : '0)
                 | (s1.left   ? WIN_LEFT   : '0)
                 | (s1.right  ? WIN_RIGHT  : '0);
        win_live = win_next & ~kill;
        n        = popcount8({win_live[8:5], win_live[3:0]});
        result_next.next_alive    = win_live[4] ? rule_cfg.survive_mask[n]
                                                : rule_cfg.birth_mask[n];
        result_next.last_of_frame = s1.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
                win_reg <= win_next;
            if (load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `LLAG_ASSERT_IMPLY(a_stall_cause, clk, rst_n, s1.valid && !s1_go, result_valid_reg && !result_ready)
    `LLAG_ASSERT_IMPLY(a_last_corner, clk, rst_n, load && s1.last, s1.bottom && s1.right)
    `LLAG_ASSERT_NEXT(a_load_shows, clk, rst_n, load, result_valid_reg)

endmodule

`default_nettype wire

[tb/sv/llag_generation_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the Life-like generation core: a bit-exact next-generation
// predictor with its own line stores and window, and the queue of due results.
// Depends on llag_pkg for the beat types, register codes and window masks.

package llag_tb_pkg;

    import llag_pkg::*;

    localparam int TB_MAX_ROWS = 1024;
    localparam int TB_MAX_COLS = 64;

    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_PAD  = 1'b1;

    localparam logic [WIN_W-1:0] WIN_CENTRE = 9'h010;
    localparam int REPORT_CAP = 100;

    class generation_scoreboard;

        logic [MASK_W-1:0] birth_mask;
        logic [MASK_W-1:0] survive_mask;
        int unsigned grid_rows;
        int unsigned grid_cols;

        bit upper_line [TB_MAX_COLS];
        bit middle_line [TB_MAX_COLS];
        logic [WIN_W-1:0] window;
        int unsigned in_row;
        int unsigned in_col;
        int unsigned emitted;

        result_t next_gen_q [$];
        int mismatches;
        int results_seen;

        function new();
            birth_mask   = BIRTH_RESET;
            survive_mask = SURVIVE_RESET;
            grid_rows    = ROWS_RESET;
            grid_cols    = COLS_RESET;
            foreach (upper_line[i])
            begin
                upper_line[i]  = 1'b0;
                middle_line[i] = 1'b0;
            end
            window       = '0;
            mismatches   = 0;
            results_seen = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            in_row  = 0;
            in_col  = 0;
            emitted = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int pending();
            return next_gen_q.size();
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BIRTH_MASK:   birth_mask = data[MASK_W-1:0];
                REG_SURVIVE_MASK: survive_mask = data[MASK_W-1:0];
                REG_GRID_ROWS:
                begin
                    grid_rows = clamp_size(data, TB_MAX_ROWS);
                    restart_frame();
                end
                REG_GRID_COLS:
                begin
                    grid_cols = clamp_size(data[COLS_FIELD_W-1:0], TB_MAX_COLS);
                    restart_frame();
                end
                default: ;
            endcase
        endfunction

        // advance the window by one accepted cell beat; queue a result if one falls due
        function void note_cell(cell_t c);
            int unsigned row;
            int unsigned col;
            int unsigned orow;
            int unsigned ocol;
            int unsigned total;
            int unsigned n;
            bit cur;
            bit up;
            bit mid;
            bit emit;
            bit last;
            logic [WIN_W-1:0] win;
            logic nxt;
            result_t want;

            row   = in_row;
            col   = in_col;
            total = grid_rows * grid_cols;
            cur   = 1'b0;
            if (c.kind == KIND_CELL && row < grid_rows)
                cur = (c.alive == 1'b1);

            up  = upper_line[col];
            mid = middle_line[col];
            upper_line[col]  = mid;
            middle_line[col] = cur;
            window = {cur, mid, up, window[WIN_W-1:3]};

            emit = (row >= 2 || (row == 1 && col >= 1)) && emitted < total;
            if (col == 0)
            begin
                orow = row - 2;
                ocol = grid_cols - 1;
            end
            else
            begin
                orow = row - 1;
                ocol = col - 1;
            end

            col++;
            if (col >= grid_cols)
            begin
                col = 0;
                row++;
            end
            in_row = row;
            in_col = col;

            if (!emit)
                return;

            win = window;
            if (orow == 0)
                win &= ~WIN_TOP;
            if (orow + 1 >= grid_rows)
                win &= ~WIN_BOTTOM;
            if (ocol == 0)
                win &= ~WIN_LEFT;
            if (ocol + 1 >= grid_cols)
                win &= ~WIN_RIGHT;

            n   = $countones(win & ~WIN_CENTRE);
            nxt = win[4] ? survive_mask[n] : birth_mask[n];

            emitted++;
            last = (emitted == total);
            if (last)
                restart_frame();

            want.next_alive    = nxt;
            want.last_of_frame = last;
            next_gen_q.push_back(want);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < REPORT_CAP)
                $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (next_gen_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat next_alive=%b last_of_frame=%b",
                                          got.next_alive, got.last_of_frame));
            end
            else
            begin
                want = next_gen_q.pop_front();
                if (got.next_alive !== want.next_alive)
                    report_mismatch($sformatf("next_alive %b, predicted %b",
                                              got.next_alive, want.next_alive));
                if (got.last_of_frame !== want.last_of_frame)
                    report_mismatch($sformatf("last_of_frame %b, predicted %b",
                                              got.last_of_frame, want.last_of_frame));
            end
            results_seen++;
        endtask

    endclass

endpackage

[tb/sv/tb_life_like_automaton_generation_core.sv]
`timescale 1ns / 1ps
// Top of the generation core testbench: clock, reset, cell and config drivers,
// a result sink with random and long back-pressure, and the final verdict.
// Depends on llag_pkg, llag_tb_pkg and life_like_automaton_generation_core.

module tb_life_like_automaton_generation_core;

    import llag_pkg::*;
    import llag_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int WARM_ITEMS    = 140;
    localparam int BIG_ROWS_PHASE = 3;

    logic                   clk;
    logic                   rst_n;
    logic                   cell_valid;
    logic                   cell_ready;
    cell_t                  cell_beat;
    logic                   result_valid;
    logic                   result_ready;
    result_t                result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    generation_scoreboard sb;
    int  items_sent;
    int  cycles;
    bit  sender_burst;
    bit  hold_request;

    life_like_automaton_generation_core #(
        .MAX_ROWS(TB_MAX_ROWS),
        .MAX_COLS(TB_MAX_COLS)
    ) dut (
        clk, rst_n,
        cell_valid, cell_ready, cell_beat,
        result_valid, result_ready, result,
        cfg_write, cfg_index, cfg_data
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** life_like_automaton_generation_core: FAILED **");
        $finish;
    end

    function automatic cell_t mk_cell(logic kind, logic alive);
        cell_t c;
        c.kind  = kind;
        c.alive = alive;
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_burst || r < 70)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_cell(input cell_t c);
        int gap;
        bit took;
        gap = pick_gap();
        if (gap > 0)
        begin
            cell_valid <= 1'b0;
            cell_beat  <= cell_t'(2'($urandom_range(0, 3)));
            repeat (gap) @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_beat  <= c;
        do
        begin
            @(negedge clk);
            took = cell_ready;
            @(posedge clk);
        end
        while (!took);
        sb.note_cell(c);
        items_sent++;
    endtask

    // drop valid, wait for every due result, then let the pipeline empty
    task automatic settle();
        cell_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input logic [3:0] sel,
                                 input logic [CFG_DATA_W-1:0] birth,
                                 input logic [CFG_DATA_W-1:0] survive,
                                 input logic [CFG_DATA_W-1:0] rows,
                                 input logic [CFG_DATA_W-1:0] cols);
        if (sel[REG_BIRTH_MASK])
            cfg_beat(REG_BIRTH_MASK, birth);
        if (sel[REG_SURVIVE_MASK])
            cfg_beat(REG_SURVIVE_MASK, survive);
        if (sel[REG_GRID_ROWS])
            cfg_beat(REG_GRID_ROWS, rows);
        if (sel[REG_GRID_COLS])
            cfg_beat(REG_GRID_COLS, cols);
        cfg_write <= 1'b0;
    endtask

    task automatic run_random_phase(input int phase);
        logic [3:0] sel;
        logic [CFG_DATA_W-1:0] b;
        logic [CFG_DATA_W-1:0] s;
        logic [CFG_DATA_W-1:0] r;
        logic [CFG_DATA_W-1:0] c;
        int pick;
        int frames;
        int density;
        int total;
        int span;
        int stop_at;
        bit big_rows;
        cell_t item;

        pick     = $urandom_range(0, 19);
        big_rows = (phase == BIG_ROWS_PHASE);
        sel      = 4'hF;
        b = CFG_DATA_W'($urandom_range(0, 2047));
        s = CFG_DATA_W'($urandom_range(0, 2047));
        if ($urandom_range(0, 5) == 0)
            b = $urandom_range(0, 1) ? 11'h000 : 11'h1FF;
        if ($urandom_range(0, 5) == 0)
            s = $urandom_range(0, 1) ? 11'h000 : 11'h1FF;
        r = CFG_DATA_W'($urandom_range(1, 8));
        c = {4'($urandom_range(0, 15)), 7'($urandom_range(1, 12))};

        if (big_rows)
        begin
            r = 11'h7FF;
            c = 11'd1;
        end
        else if (phase == 1 || pick == 0)
        begin
            c = $urandom_range(0, 1) ? 11'h07F : 11'd64;
            r = CFG_DATA_W'($urandom_range(1, 3));
        end
        else if (pick == 1)
        begin
            c = 11'h780;
            r = CFG_DATA_W'($urandom_range(1, 16));
        end
        else if (pick == 2)
        begin
            r = 11'd0;
            c = CFG_DATA_W'($urandom_range(1, 16));
        end
        else if (pick < 7)
            sel = 4'h3;

        settle();
        apply_setting(sel, b, s, r, c);
        if (big_rows)
            hold_request = 1'b1;
        sender_burst = ($urandom_range(0, 3) == 0);
        frames = big_rows ? 1 : $urandom_range(1, 2);

        repeat (frames)
        begin
            total   = sb.grid_rows * sb.grid_cols;
            span    = total + sb.grid_cols + 1;
            stop_at = span;
            if (!big_rows && $urandom_range(0, 7) == 0)
                stop_at = $urandom_range(1, span);
            density = $urandom_range(0, 100);
            for (int k = 0; k < stop_at; k++)
            begin
                if (k < total)
                    item = mk_cell(($urandom_range(0, 15) == 0) ? KIND_PAD : KIND_CELL,
                                   ($urandom_range(0, 99) < density));
                else
                    item = cell_t'(2'($urandom_range(0, 3)));
                send_cell(item);
            end
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int mode_left;
        bit free_run;
        bit ready;

        stall_left = 0;
        hold_left  = 0;
        mode_left  = 0;
        free_run   = 1'b0;
        result_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && result_valid && result_ready)
                sb.check_result(result);
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                free_run  = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 300);
            end
            else
                mode_left--;

            if (hold_left > 0)
            begin
                hold_left--;
                ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                ready = 1'b0;
            end
            else if (!free_run && $urandom_range(0, 4) == 0)
            begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
                ready = 1'b0;
            end
            else
                ready = 1'b1;
            result_ready <= ready;
        end
    end

    initial
    begin : stimulus
        int phase;

        sb = new();
        items_sent   = 0;
        sender_burst = 1'b0;
        hold_request = 1'b0;
        rst_n      <= 1'b0;
        cell_valid <= 1'b0;
        cell_beat  <= mk_cell(KIND_CELL, 1'b0);
        cfg_write  <= 1'b0;
        cfg_index  <= REG_BIRTH_MASK;
        cfg_data   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry and rule, cut short by the first geometry write
        repeat (WARM_ITEMS)
            send_cell(mk_cell(($urandom_range(0, 7) == 0) ? KIND_PAD : KIND_CELL,
                              1'($urandom_range(0, 1))));

        // single-cell grid, geometry writes of zero
        settle();
        apply_setting(4'hF, 11'h1FF, 11'h1FF, 11'd0, 11'd0);
        send_cell(mk_cell(KIND_CELL, 1'b1));
        send_cell(mk_cell(KIND_PAD, 1'b0));
        send_cell(mk_cell(KIND_PAD, 1'b1));

        // 2x2 grid with a pad inside the grid and high data bits on the masks
        settle();
        apply_setting(4'hF, 11'h7FF, 11'h600, 11'd2, 11'd2);
        send_cell(mk_cell(KIND_CELL, 1'b1));
        send_cell(mk_cell(KIND_PAD, 1'b1));
        send_cell(mk_cell(KIND_CELL, 1'b1));
        send_cell(mk_cell(KIND_CELL, 1'b0));
        send_cell(mk_cell(KIND_PAD, 1'b0));
        send_cell(mk_cell(KIND_CELL, 1'b1));
        send_cell(mk_cell(KIND_PAD, 1'b1));

        // full 3x3 grid of live cells: corner, edge and centre neighbour counts
        settle();
        apply_setting(4'hF, 11'h000, 11'h1FF, 11'd3, 11'd3);
        repeat (9) send_cell(mk_cell(KIND_CELL, 1'b1));
        repeat (4) send_cell(mk_cell(KIND_PAD, 1'b0));

        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            run_random_phase(phase);
            phase++;
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** life_like_automaton_generation_core: PASSED **");
        else
            $display("** life_like_automaton_generation_core: FAILED **");
        $finish;
    end

endmodule
